@@ rtl/pcipher_pkg.sv @@
package pcipher_pkg;

    localparam int KEY_MAX    = 64;
    localparam int KEY_ROUNDS = 4096;
    localparam int KEY_AW     = $clog2(KEY_MAX);
    localparam int LEN_W      = 7;
    localparam int ROUND_W    = $clog2(KEY_ROUNDS) + 1;
    localparam int SEED_W     = 64;
    localparam int SEED_TOP   = 56;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_INIT = 2'd1,
        OP_ENC  = 2'd2,
        OP_DEC  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_KEY_RD,
        S_INV_RD,
        S_MIX_RD,
        S_MIX_W1,
        S_MIX_W2,
        S_RESULT
    } t_state;

    // Source of the byte that a mix step works with.
    typedef enum logic [1:0] {
        V_REG,
        V_KEY,
        V_INV
    } t_vsrc;

    typedef struct packed {
        logic  accept;
        logic  key_wr;
        logic  init_start;
        logic  clr_step;
        logic  key_rd;
        logic  inv_rd;
        logic  mix_rd;
        t_vsrc v_src;
        logic  wr_first;
        logic  wr_second;
        logic  round_step;
        logic  out_load;
        logic  res_inv;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic len_zero;
        logic round_last;
        logic out_free;
    } t_sts;

endpackage

@@ rtl/pcipher_ctrl.sv @@
module pcipher_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_in_operation,
    input  logic [5:0]          i_in_key_index,
    input  pcipher_pkg::t_sts   i_sts,
    output logic                o_in_ready,
    output pcipher_pkg::t_cmd   o_cmd
);

    pcipher_pkg::t_state r_state, n_state;
    pcipher_pkg::t_op    r_op, n_op;
    pcipher_pkg::t_op    in_op;
    logic                in_accept;

    assign in_op     = pcipher_pkg::t_op'(i_in_operation);
    assign in_accept = i_in_valid && (r_state == pcipher_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcipher_pkg::S_IDLE;
            r_op    <= pcipher_pkg::OP_LOAD;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        case (r_state)
            pcipher_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_op = in_op;
                    case (in_op)
                        pcipher_pkg::OP_INIT: n_state = pcipher_pkg::S_CLEAR;
                        pcipher_pkg::OP_ENC:  n_state = pcipher_pkg::S_MIX_RD;
                        pcipher_pkg::OP_DEC:  n_state = pcipher_pkg::S_INV_RD;
                        default:              n_state = pcipher_pkg::S_IDLE;
                    endcase
                end
            end
            pcipher_pkg::S_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = i_sts.len_zero ? pcipher_pkg::S_IDLE : pcipher_pkg::S_KEY_RD;
                end
            end
            pcipher_pkg::S_KEY_RD: n_state = pcipher_pkg::S_MIX_RD;
            pcipher_pkg::S_INV_RD: n_state = pcipher_pkg::S_MIX_RD;
            pcipher_pkg::S_MIX_RD: n_state = pcipher_pkg::S_MIX_W1;
            pcipher_pkg::S_MIX_W1: n_state = pcipher_pkg::S_MIX_W2;
            pcipher_pkg::S_MIX_W2: begin
                if (r_op == pcipher_pkg::OP_INIT) begin
                    n_state = i_sts.round_last ? pcipher_pkg::S_IDLE : pcipher_pkg::S_KEY_RD;
                end else begin
                    n_state = pcipher_pkg::S_RESULT;
                end
            end
            pcipher_pkg::S_RESULT: begin
                if (i_sts.out_free) begin
                    n_state = pcipher_pkg::S_IDLE;
                end
            end
            default: n_state = pcipher_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            pcipher_pkg::S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.accept    = in_accept;
                o_cmd.init_start = in_accept && (in_op == pcipher_pkg::OP_INIT);
                o_cmd.key_wr    = in_accept && (in_op == pcipher_pkg::OP_LOAD) &&
                                  (pcipher_pkg::LEN_W'(i_in_key_index) <
                                   pcipher_pkg::LEN_W'(pcipher_pkg::KEY_MAX));
            end
            pcipher_pkg::S_CLEAR:  o_cmd.clr_step = 1'b1;
            pcipher_pkg::S_KEY_RD: o_cmd.key_rd   = 1'b1;
            pcipher_pkg::S_INV_RD: o_cmd.inv_rd   = 1'b1;
            pcipher_pkg::S_MIX_RD: begin
                o_cmd.mix_rd = 1'b1;
                case (r_op)
                    pcipher_pkg::OP_INIT: o_cmd.v_src = pcipher_pkg::V_KEY;
                    pcipher_pkg::OP_DEC:  o_cmd.v_src = pcipher_pkg::V_INV;
                    default:              o_cmd.v_src = pcipher_pkg::V_REG;
                endcase
            end
            pcipher_pkg::S_MIX_W1: o_cmd.wr_first = 1'b1;
            pcipher_pkg::S_MIX_W2: begin
                o_cmd.wr_second  = 1'b1;
                o_cmd.round_step = (r_op == pcipher_pkg::OP_INIT);
            end
            pcipher_pkg::S_RESULT: begin
                o_cmd.out_load = i_sts.out_free;
                o_cmd.res_inv  = (r_op == pcipher_pkg::OP_DEC);
            end
            default: o_in_ready = 1'b0;
        endcase
    end

endmodule

@@ rtl/pcipher_dp.sv @@
module pcipher_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_in_data_byte,
    input  logic [5:0]          i_in_key_index,
    input  logic [6:0]          i_in_key_length,
    input  logic                i_out_ready,
    input  pcipher_pkg::t_cmd   i_cmd,
    output pcipher_pkg::t_sts   o_sts,
    output logic                o_out_valid,
    output logic [7:0]          o_out_result_byte
);

    logic [7:0] r_fwd_mem [256];
    logic [7:0] r_inv_mem [256];
    logic [7:0] r_key_mem [pcipher_pkg::KEY_MAX];

    logic [pcipher_pkg::SEED_W-1:0]  r_seed;
    logic [pcipher_pkg::ROUND_W-1:0] r_round;
    logic [pcipher_pkg::KEY_AW-1:0]  r_ptr;
    logic [pcipher_pkg::LEN_W-1:0]   r_len;
    logic [7:0]                      r_clr;
    logic [7:0]                      r_v;
    logic [7:0]                      r_fa;
    logic [7:0]                      r_fb;
    logic [7:0]                      r_key_q;
    logic [7:0]                      r_inv_q;
    logic                            r_out_valid;
    logic [7:0]                      r_out_byte;

    logic [pcipher_pkg::SEED_W-1:0]  n_seed;
    logic [7:0]                      seed_hi;
    logic [7:0]                      v_cur;
    logic                            mem_we;
    logic [7:0]                      f_wa, f_wd, i_wa, i_wd;
    logic                            ptr_wrap;

    assign seed_hi  = r_seed[pcipher_pkg::SEED_W-1:pcipher_pkg::SEED_TOP];
    assign ptr_wrap = (pcipher_pkg::LEN_W'(r_ptr) == (r_len - pcipher_pkg::LEN_W'(1)));

    // The multiplier is 2^56 - 5, so the product reduces to shifts and subtracts.
    assign n_seed = (r_seed << pcipher_pkg::SEED_TOP) - (r_seed << 2) - r_seed +
                    pcipher_pkg::SEED_W'(r_v);

    always_comb begin
        case (i_cmd.v_src)
            pcipher_pkg::V_KEY: v_cur = r_key_q;
            pcipher_pkg::V_INV: v_cur = r_inv_q;
            default:            v_cur = r_v;
        endcase
    end

    always_comb begin
        mem_we = i_cmd.clr_step || i_cmd.wr_first || i_cmd.wr_second;
        f_wa   = r_clr;
        f_wd   = r_clr;
        i_wa   = r_clr;
        i_wd   = r_clr;
        if (i_cmd.wr_first) begin
            f_wa = r_v;
            f_wd = r_fb;
            i_wa = r_fb;
            i_wd = r_v;
        end else if (i_cmd.wr_second) begin
            f_wa = seed_hi;
            f_wd = r_fa;
            i_wa = r_fa;
            i_wd = seed_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_fwd_mem[f_wa] <= f_wd;
            r_inv_mem[i_wa] <= i_wd;
        end
        if (i_cmd.mix_rd) begin
            r_fa <= r_fwd_mem[v_cur];
            r_fb <= r_fwd_mem[seed_hi];
        end
        if (i_cmd.inv_rd) begin
            r_inv_q <= r_inv_mem[r_v];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_wr) begin
            r_key_mem[i_in_key_index] <= i_in_data_byte;
        end
        if (i_cmd.key_rd) begin
            r_key_q <= r_key_mem[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_v <= i_in_data_byte;
        end else if (i_cmd.mix_rd) begin
            r_v <= v_cur;
        end
        if (i_cmd.init_start) begin
            r_len <= (i_in_key_length > pcipher_pkg::LEN_W'(pcipher_pkg::KEY_MAX)) ?
                     pcipher_pkg::LEN_W'(pcipher_pkg::KEY_MAX) : i_in_key_length;
        end
        if (i_cmd.out_load) begin
            r_out_byte <= i_cmd.res_inv ? r_v : r_fa;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= '0;
            r_round     <= '0;
            r_ptr       <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.init_start) begin
                r_seed  <= '0;
                r_round <= '0;
                r_ptr   <= '0;
                r_clr   <= '0;
            end else begin
                if (i_cmd.clr_step) begin
                    r_clr <= r_clr + 8'd1;
                end
                if (i_cmd.wr_second) begin
                    r_seed <= n_seed;
                end
                if (i_cmd.round_step) begin
                    r_round <= o_sts.round_last ? '0 : r_round + pcipher_pkg::ROUND_W'(1);
                    r_ptr   <= ptr_wrap ? '0 : r_ptr + pcipher_pkg::KEY_AW'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.clr_last   = (r_clr == 8'hFF);
    assign o_sts.len_zero   = (r_len == '0);
    assign o_sts.round_last = (r_round == pcipher_pkg::ROUND_W'(pcipher_pkg::KEY_ROUNDS - 1));
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_out_result_byte = r_out_byte;

endmodule

@@ rtl/permutation_stream_cipher_top.sv @@
// Byte stream cipher built on a keyed 256-entry permutation and its inverse.
// The input channel (i_in_valid / o_in_ready) carries items of four kinds:
// load key byte, initialize, encode and decode. The output channel
// (o_out_valid / i_out_ready) carries one result byte for each encode or
// decode item and nothing for the other kinds.
// A load key byte item leaves the block idle; the next item can follow at once.
// An initialize item sweeps both tables to identity, one entry per cycle,
// then, unless the key length is zero, runs 4096 key rounds, each a key
// store read, a table read and two table writes.
// An encode item passes through a table read, two table writes and a
// result step before the block is ready again; a decode item adds an
// inverse table read first. A swap needs two writes after the read
// because each table has a single write port. The result appears in the
// output register as ready rises again.
// Reset clears the controller, the seed and the output valid flag; the tables
// and the key store hold nothing defined until an initialize item and key
// loads have run. If the receiver stalls, the result is held and the block
// waits before finishing its next encode or decode item.
module permutation_stream_cipher_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_in_operation,
    input  logic [7:0] i_in_data_byte,
    input  logic [5:0] i_in_key_index,
    input  logic [6:0] i_in_key_length,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_result_byte
);

    pcipher_pkg::t_cmd w_cmd;
    pcipher_pkg::t_sts w_sts;

    // The controller sequences each item; it sees the opcode and key index only.
    pcipher_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_operation (i_in_operation),
        .i_in_key_index (i_in_key_index),
        .i_sts          (w_sts),
        .o_in_ready     (o_in_ready),
        .o_cmd          (w_cmd)
    );

    // The datapath holds the tables, key store, seed, counters and output register.
    pcipher_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_data_byte    (i_in_data_byte),
        .i_in_key_index    (i_in_key_index),
        .i_in_key_length   (i_in_key_length),
        .i_out_ready       (i_out_ready),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .o_out_valid       (o_out_valid),
        .o_out_result_byte (o_out_result_byte)
    );

    // A result is only written into a free output register.
    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free)
        else $error("result loaded into an occupied output register");

    // A loaded result is offered on the next cycle.
    a_out_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> o_out_valid)
        else $error("loaded result not presented");

    // An encode or decode item keeps the block busy after its acceptance.
    a_byte_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready &&
         (i_in_operation == pcipher_pkg::OP_ENC || i_in_operation == pcipher_pkg::OP_DEC))
        |=> !o_in_ready)
        else $error("new item accepted during a byte operation");

    // Table reads for a mix step never overlap acceptance of a new item.
    a_mix_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.mix_rd |-> !o_in_ready)
        else $error("ready raised during a mix step");

endmodule

@@ tb/sv/permutation_stream_cipher_top_test.sv @@
`timescale 1ns / 1ps

module permutation_stream_cipher_top_test;

    // Longest sender gap and longest receiver stall, in cycles. They also feed the
    // cycle limit of the watchdog.
    localparam int MAX_GAP   = 10;
    localparam int MAX_STALL = 12;
    // Cycles an initialize item keeps the block busy, rounded up: table sweep plus key rounds.
    localparam int INIT_CYCLES = 16700;
    localparam int RANDOM_ITEMS = 750;
    localparam logic [63:0] SEED_STEP = 64'd72057594037927931;

    // One input item as the sender queues it. A set hold_for_drain flag makes the
    // driver wait until every outstanding result byte has been taken before it
    // offers this item.
    typedef struct {
        pcipher_pkg::t_op op;
        logic [7:0]       data;
        logic [5:0]       index;
        logic [6:0]       length;
        bit               hold_for_drain;
    } t_cipher_item;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [1:0] i_in_operation = pcipher_pkg::OP_LOAD;
    logic [7:0] i_in_data_byte = 8'd0;
    logic [5:0] i_in_key_index = 6'd0;
    logic [6:0] i_in_key_length = 7'd0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_out_result_byte;

    permutation_stream_cipher_top DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_in_operation    (i_in_operation),
        .i_in_data_byte    (i_in_data_byte),
        .i_in_key_index    (i_in_key_index),
        .i_in_key_length   (i_in_key_length),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_result_byte (o_out_result_byte)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Items waiting to be offered, and result bytes the cipher owes the receiver.
    t_cipher_item pending_items[$];
    logic [7:0]   cipher_bytes_due[$];

    // Running counts. bytes_predicted is only touched by the driver, bytes_taken
    // only by the monitor (nonblocking), so the driver sees a stable value of it.
    int unsigned bytes_predicted = 0;
    int unsigned bytes_taken = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_limit = 32'd8000000;

    // Predicted cipher state: permutation, its inverse, seed and key store.
    logic [7:0]  fwd_perm [256];
    logic [7:0]  inv_perm [256];
    logic [7:0]  key_bytes [pcipher_pkg::KEY_MAX];
    logic [63:0] mix_seed = 64'd0;

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    // Swap the entry for byte v with the entry the seed's top byte points at, keep
    // the inverse consistent, then advance the seed.
    function automatic void perm_mix(logic [7:0] v);
        logic [7:0] s;
        logic [7:0] held;
        s = mix_seed[63:56];
        held = fwd_perm[v];
        fwd_perm[v] = fwd_perm[s];
        fwd_perm[s] = held;
        inv_perm[fwd_perm[v]] = v;
        inv_perm[fwd_perm[s]] = s;
        mix_seed = mix_seed * SEED_STEP + {56'd0, v};
    endfunction

    // Identity tables and a zero seed, then the key schedule. A length past the
    // key store saturates; a zero length leaves the identity in place.
    function automatic void rekey(logic [6:0] length);
        int n;
        for (int i = 0; i < 256; i++) begin
            fwd_perm[i] = 8'(i);
            inv_perm[i] = 8'(i);
        end
        mix_seed = 64'd0;
        n = (length > pcipher_pkg::KEY_MAX) ? pcipher_pkg::KEY_MAX : int'(length);
        if (n != 0) begin
            for (int r = 0; r < pcipher_pkg::KEY_ROUNDS; r++) begin
                perm_mix(key_bytes[r % n]);
            end
        end
    endfunction

    // Apply one accepted item to the predicted state and, for an encode or decode item, queue its result byte.
    function automatic void predict_cipher(t_cipher_item item);
        logic [7:0] r;
        case (item.op)
            pcipher_pkg::OP_LOAD: key_bytes[item.index] = item.data;
            pcipher_pkg::OP_INIT: rekey(item.length);
            pcipher_pkg::OP_ENC: begin
                r = fwd_perm[item.data];
                perm_mix(item.data);
                cipher_bytes_due.push_back(r);
                bytes_predicted++;
            end
            default: begin
                r = inv_perm[item.data];
                perm_mix(r);
                cipher_bytes_due.push_back(r);
                bytes_predicted++;
            end
        endcase
    endfunction

    // Driver. An item in flight stays on the port until the handshake; after that
    // the next item goes out at once unless a gap between bursts is running or
    // the item asks for the pipeline to drain first.
    int burst_left;
    int gap_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left = $urandom_range(1, 24);
            gap_left = 0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) begin
                predict_cipher(pending_items.pop_front());
            end
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() > 0 &&
                         (!pending_items[0].hold_for_drain ||
                          bytes_predicted == bytes_taken)) begin
                i_in_valid      <= 1'b1;
                i_in_operation  <= pending_items[0].op;
                i_in_data_byte  <= pending_items[0].data;
                i_in_key_index  <= pending_items[0].index;
                i_in_key_length <= pending_items[0].length;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor. Every taken result byte is checked against the oldest prediction.
    // The receiver keeps changing its stall habit: sometimes it never stalls,
    // sometimes it stalls now and then, sometimes most of the time.
    int stall_left;
    int stall_mode;
    int mode_cycles;

    always @(posedge i_clk) begin
        logic [7:0] want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left = 0;
            stall_mode = 0;
            mode_cycles = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                bytes_taken <= bytes_taken + 1;
                if (cipher_bytes_due.size() == 0) begin
                    note_failure($sformatf("result byte %02h with no item waiting for it",
                                           o_out_result_byte));
                end else begin
                    want = cipher_bytes_due.pop_front();
                    if (o_out_result_byte !== want) begin
                        note_failure($sformatf("result_byte expected %02h got %02h",
                                               want, o_out_result_byte));
                    end
                end
            end
            mode_cycles++;
            if (mode_cycles >= 400) begin
                mode_cycles = 0;
                stall_mode = $urandom_range(0, 2);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (stall_mode == 1 && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 3);
                i_out_ready <= 1'b0;
            end else if (stall_mode == 2 && $urandom_range(0, 1) == 0) begin
                stall_left = $urandom_range(0, MAX_STALL - 1);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Stimulus bookkeeping. key_loaded tracks which key store entries have been
    // written so that no initialize ever reads an entry that was never loaded.
    int unsigned item_count = 0;
    int unsigned init_count = 0;
    bit [pcipher_pkg::KEY_MAX-1:0] key_loaded = '0;

    task automatic queue_item(pcipher_pkg::t_op op, logic [7:0] data, logic [5:0] index,
                              logic [6:0] length, bit hold_for_drain);
        t_cipher_item item;
        item.op = op;
        item.data = data;
        item.index = index;
        item.length = length;
        item.hold_for_drain = hold_for_drain;
        pending_items.push_back(item);
        item_count++;
        if (op == pcipher_pkg::OP_INIT) begin
            init_count++;
        end
        if (op == pcipher_pkg::OP_LOAD) begin
            key_loaded[index] = 1'b1;
        end
    endtask

    initial begin : stimulus
        int order [pcipher_pkg::KEY_MAX];
        int pick;
        int run;
        logic [6:0] length;

        // Zero key length: tables stay identity, so encode and decode of the
        // extreme bytes start from a known permutation.
        queue_item(pcipher_pkg::OP_INIT, 8'h00, 6'd0, 7'd0, 1'b0);
        queue_item(pcipher_pkg::OP_ENC, 8'h00, 6'd0, 7'd0, 1'b0);
        queue_item(pcipher_pkg::OP_ENC, 8'hFF, 6'd0, 7'd0, 1'b0);
        queue_item(pcipher_pkg::OP_DEC, 8'h00, 6'd0, 7'd0, 1'b0);
        queue_item(pcipher_pkg::OP_DEC, 8'hFF, 6'd0, 7'd0, 1'b0);
        // Key bytes at both ends of the store and with extreme values.
        queue_item(pcipher_pkg::OP_LOAD, 8'hFF, 6'd0, 7'd0, 1'b0);
        queue_item(pcipher_pkg::OP_LOAD, 8'h00, 6'd63, 7'd0, 1'b0);
        queue_item(pcipher_pkg::OP_LOAD, 8'h5A, 6'd1, 7'd0, 1'b0);
        // A one-byte key, then a two-byte key.
        queue_item(pcipher_pkg::OP_INIT, 8'h00, 6'd0, 7'd1, 1'b0);
        queue_item(pcipher_pkg::OP_ENC, 8'h80, 6'd0, 7'd0, 1'b0);
        queue_item(pcipher_pkg::OP_DEC, 8'h7F, 6'd0, 7'd0, 1'b0);
        queue_item(pcipher_pkg::OP_INIT, 8'h00, 6'd0, 7'd2, 1'b0);
        queue_item(pcipher_pkg::OP_ENC, 8'h00, 6'd0, 7'd0, 1'b0);
        queue_item(pcipher_pkg::OP_ENC, 8'hFF, 6'd0, 7'd0, 1'b0);
        queue_item(pcipher_pkg::OP_DEC, 8'h00, 6'd0, 7'd0, 1'b0);
        queue_item(pcipher_pkg::OP_DEC, 8'hFF, 6'd0, 7'd0, 1'b0);
        // Hold back until the pipeline is empty, then go on with a back-to-back pair.
        queue_item(pcipher_pkg::OP_ENC, 8'h3C, 6'd0, 7'd0, 1'b1);
        queue_item(pcipher_pkg::OP_DEC, 8'hC3, 6'd0, 7'd0, 1'b0);

        // Fill the whole key store in a shuffled order so any key length is legal
        // from here on, including lengths that saturate.
        for (int i = 0; i < pcipher_pkg::KEY_MAX; i++) begin
            order[i] = i;
        end
        for (int i = pcipher_pkg::KEY_MAX - 1; i > 0; i--) begin
            pick = $urandom_range(0, i);
            run = order[i];
            order[i] = order[pick];
            order[pick] = run;
        end
        foreach (order[i]) begin
            queue_item(pcipher_pkg::OP_LOAD, 8'($urandom), 6'(order[i]), 7'($urandom), 1'b0);
        end
        queue_item(pcipher_pkg::OP_INIT, 8'($urandom), 6'($urandom), 7'd127, 1'b0);
        queue_item(pcipher_pkg::OP_ENC, 8'($urandom), 6'd0, 7'd0, 1'b0);
        queue_item(pcipher_pkg::OP_INIT, 8'($urandom), 6'($urandom), 7'd64, 1'b0);
        queue_item(pcipher_pkg::OP_DEC, 8'($urandom), 6'd0, 7'd0, 1'b0);

        // Random part: sessions of a few key updates, one initialize and a long
        // run of encode and decode items, with stray key loads mixed into the runs.
        // Sessions are long so that the slow initialize stays a small share.
        while (item_count < RANDOM_ITEMS + 18) begin
            run = $urandom_range(0, 6);
            repeat (run) begin
                queue_item(pcipher_pkg::OP_LOAD, 8'($urandom), 6'($urandom),
                           7'($urandom), 1'b0);
            end
            case ($urandom_range(0, 9))
                0: length = 7'd0;
                1: length = 7'd64;
                2: length = 7'($urandom_range(65, 127));
                3: length = 7'd1;
                default: length = 7'($urandom_range(1, 63));
            endcase
            if (key_loaded != '1 && length > 2) begin
                length = 7'd2;
            end
            queue_item(pcipher_pkg::OP_INIT, 8'($urandom), 6'($urandom), length, 1'b0);
            run = $urandom_range(30, 70);
            repeat (run) begin
                if ($urandom_range(0, 29) == 0) begin
                    queue_item(pcipher_pkg::OP_LOAD, 8'($urandom), 6'($urandom),
                               7'($urandom), 1'b0);
                end
                queue_item($urandom_range(0, 1) ? pcipher_pkg::OP_DEC : pcipher_pkg::OP_ENC,
                           8'($urandom), 6'($urandom), 7'($urandom),
                           $urandom_range(0, 99) == 0);
            end
        end

        cycle_limit = 4 * (init_count * INIT_CYCLES + item_count * (8 + MAX_GAP + MAX_STALL))
                      + 20000;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Let every item go in, every owed byte come out, then a short tail in
        // which a spurious extra result would still be caught.
        while (pending_items.size() > 0 || i_in_valid) @(negedge i_clk);
        while (cipher_bytes_due.size() > 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (cipher_bytes_due.size() > 0) begin
            note_failure($sformatf("%0d result bytes never arrived", cipher_bytes_due.size()));
        end
        if (fail_count == 0) begin
            $display("permutation_stream_cipher_top test passed");
        end else begin
            $display("permutation_stream_cipher_top test failed");
        end
        $finish;
    end

    // A hung handshake ends the run here.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < cycle_limit) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("permutation_stream_cipher_top test failed");
        $finish;
    end

endmodule
